[src/bsrch_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Controller state encoding and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsrch_pkg;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_CHECK = 3'b100
   } state_type;

   typedef struct packed {
      logic wr;
      logic load;
      logic probe;
      logic narrow;
      logic hit;
      logic miss;
   } cmd_type;

   typedef struct packed {
      logic range_open;
      logic hit;
   } status_type;

endpackage

[src/bsrch_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsrch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bsrch_ctrl.sv]
// ----------------------------------------------------------------------------
// Binary search controller
// Accepts items and sequences the probe and check steps of a search.
// ----------------------------------------------------------------------------
module bsrch_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_kind,
   input  bsrch_pkg::status_type  status,
   output bsrch_pkg::cmd_type     cmd,
   output logic                   busy
);
   import bsrch_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind) begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.range_open) begin
               cmd.probe = 1'b1;
               state_in  = ST_CHECK;
            end else begin
               cmd.miss = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.hit) begin
               cmd.hit  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.narrow = 1'b1;
               state_in   = ST_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> $past(state_ff) == ST_PROBE)
      else $error("check step not preceded by a probe");

   a_no_accept_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load && !cmd.wr)
      else $error("item taken while busy");

   a_result_ends_search: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit || cmd.miss) |=> state_ff == ST_IDLE)
      else $error("search did not end after its result");

endmodule

[src/bsrch_dp.sv]
// ----------------------------------------------------------------------------
// Binary search datapath
// Table memory, search bounds, key register, size register and result
// registers.
// ----------------------------------------------------------------------------
module bsrch_dp #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsrch_pkg::cmd_type    cmd,
   output bsrch_pkg::status_type status,
   input  logic [9:0]            req_entry_index,
   input  logic [31:0]           req_entry_value,
   input  logic [31:0]           req_search_key,
   input  logic                  csr_wr_en,
   input  logic [10:0]           csr_wr_data,
   output logic                  rsp_valid,
   output logic                  rsp_found,
   output logic [9:0]            rsp_position
);
   import bsrch_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int BW = IW + 1;

   logic [10:0]            table_size_ff;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [BW-1:0]          low_ff, low_in;
   logic [BW-1:0]          high_ff, high_in;
   logic [IW-1:0]          probe_ff, probe_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [9:0]             rsp_position_ff, rsp_position_in;

   logic [BW:0]            mid_sum;
   logic [IW-1:0]          mid;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic [63:0]            key_ext;
   logic [63:0]            value_ext;
   logic [BW+10:0]         size_ext;
   logic [BW+10:0]         depth_ext;
   logic [BW+9:0]          idx_ext;
   logic                   wr_en;
   logic [IW+9:0]          pos_ext;
   logic                   key_lt;

   assign key_ext   = {{32{req_search_key[31]}}, req_search_key};
   assign value_ext = {{32{req_entry_value[31]}}, req_entry_value};
   assign size_ext  = {{BW{1'b0}}, table_size_ff};
   assign depth_ext = (BW + 11)'(TABLE_DEPTH);
   assign idx_ext   = {{BW{1'b0}}, req_entry_index};
   assign wr_en     = cmd.wr && (idx_ext < (BW + 10)'(TABLE_DEPTH));

   assign mid_sum = {1'b0, low_ff} + {1'b0, high_ff} - {{BW{1'b0}}, 1'b1};
   assign mid     = mid_sum[IW:1];
   assign pos_ext = {10'b0, probe_ff};
   assign key_lt  = $signed(key_ff) < $signed(rd_data);

   assign status.range_open = (low_ff < high_ff);
   assign status.hit        = ($signed(rd_data) == $signed(key_ff));

   bsrch_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ext[IW-1:0]),
      .wr_data (value_ext[VALUE_WIDTH-1:0]),
      .rd_en   (cmd.probe),
      .rd_addr (mid),
      .rd_data (rd_data)
   );

   always_comb begin
      key_in          = key_ff;
      low_in          = low_ff;
      high_in         = high_ff;
      probe_in        = probe_ff;
      rsp_valid_in    = 1'b0;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (cmd.load) begin
         key_in = key_ext[VALUE_WIDTH-1:0];
         low_in = '0;
         if (size_ext > depth_ext) begin
            high_in = depth_ext[BW-1:0];
         end else begin
            high_in = size_ext[BW-1:0];
         end
      end
      if (cmd.probe) begin
         probe_in = mid;
      end
      if (cmd.narrow) begin
         if (key_lt) begin
            high_in = {1'b0, probe_ff};
         end else begin
            low_in = {1'b0, probe_ff} + {{IW{1'b0}}, 1'b1};
         end
      end
      if (cmd.hit) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = 1'b1;
         rsp_position_in = pos_ext[9:0];
      end
      if (cmd.miss) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = 1'b0;
         rsp_position_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
         low_ff        <= '0;
         high_ff       <= '0;
         probe_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            table_size_ff <= csr_wr_data;
         end
         low_ff       <= low_in;
         high_ff      <= high_in;
         probe_ff     <= probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

[src/sorted_table_binary_search.sv]
// Write items give no result; busy stays low.
// A search item makes P probes (at most log2(TABLE_DEPTH) + 1), each probe one
// registered table read and one compare; a match ends in the check step and a
// miss in a further probe step that finds the range empty.
// The result strobe rises in the cycle after the last step; the next item may
// be accepted in that same cycle. Synchronous reset clears the table size and
// controller; table contents are undefined until written.
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of signed values and searches its first table_size entries
// by bisection, reporting whether the key was found and where.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [9:0]  req_entry_index,
   input  logic [31:0] req_entry_value,
   input  logic [31:0] req_search_key,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [9:0]  rsp_position
);
   import bsrch_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsrch_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   bsrch_dp #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule
